@@ rtl/aff_pkg.sv @@
package aff_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int DIV_STAGES   = 32;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_ROTATION   = 3'd2,
      CSR_SCALE_X    = 3'd3,
      CSR_SCALE_Y    = 3'd4,
      CSR_POSITION_X = 3'd5,
      CSR_POSITION_Y = 3'd6
   } aff_csr_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_SATURATED  = 2'd1,
      STATUS_ZERO_SCALE = 2'd2
   } aff_status_type;

   localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] value;
      logic        clipped;
   } aff_sat_type;

   function automatic aff_sat_type sat32(input logic signed [71:0] v);
      aff_sat_type r;
      if (v > 72'sd2147483647) begin
         r.value   = WORD_MAX;
         r.clipped = 1'b1;
      end else if (v < -72'sd2147483648) begin
         r.value   = WORD_MIN;
         r.clipped = 1'b1;
      end else begin
         r.value   = v[31:0];
         r.clipped = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051E;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2F;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2FA;
         5'd15:   r = 32'h0000517D;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A30;
         5'd19:   r = 32'h00000518;
         5'd20:   r = 32'h0000028C;
         5'd21:   r = 32'h00000146;
         5'd22:   r = 32'h000000A3;
         5'd23:   r = 32'h00000051;
         5'd24:   r = 32'h00000029;
         5'd25:   r = 32'h00000014;
         5'd26:   r = 32'h0000000A;
         5'd27:   r = 32'h00000005;
         5'd28:   r = 32'h00000003;
         5'd29:   r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/aff_req_if.sv @@
interface aff_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;

   modport source (output valid, output operation, output point_x, output point_y,
                   input ready);
   modport sink   (input valid, input operation, input point_x, input point_y,
                   output ready);
endinterface

@@ rtl/aff_rsp_if.sv @@
interface aff_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_x;
   logic signed [31:0] result_y;
   logic [1:0]         status;

   modport source (output valid, output result_x, output result_y, output status,
                   input ready);
   modport sink   (input valid, input result_x, input result_y, input status,
                   output ready);
endinterface

@@ rtl/affine_point_transform_2d.sv @@
// Affine point transform, one 2D point per transaction.
// req_if carries operation (0 forward, 1 inverse) and point_x/point_y in
// signed Q16.16; rsp_if returns result_x/result_y and status
// (0 ok, 1 saturated, 2 zero scale in inverse).
// Registers are written through csr_wr_en/csr_index/csr_data; the user must
// write them only while the block is idle, and the block itself does not
// enforce this; a write to an index past the last register is dropped.
// A new request is taken every cycle while the receiver does not stall and
// the CORDIC unit is idle. The pipeline depth comes from the 32-stage restoring
// divider that serves the inverse path; forward points ride alongside it.
// Sine and cosine come from an iterative CORDIC unit that runs after reset
// and after each rotation write; req_if.ready stays low while it runs.
// Reset clears all valid bits and loads the register defaults (unit scale).
// When the receiver stalls, the whole pipeline holds in place and ready
// drops; nothing is lost or repeated.
module affine_point_transform_2d
   import aff_pkg::*;
#(
   parameter int TRIG_FRACTION_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   aff_req_if.sink     req_if,
   aff_rsp_if.source   rsp_if
);

   localparam int F  = TRIG_FRACTION_BITS;
   localparam int PW = F + 34;
   localparam int SW = F + 35;

   typedef struct packed {
      logic        vld;
      logic        op;
      logic        sat;
      logic        zero_x;
      logic        zero_y;
      logic        neg_x;
      logic        neg_y;
      logic        ovf_x;
      logic        ovf_y;
      logic [31:0] val_x;
      logic [31:0] val_y;
   } side_type;

   logic signed [31:0] origin_x_ff, origin_y_ff, scale_x_ff, scale_y_ff;
   logic signed [31:0] position_x_ff, position_y_ff;
   logic [15:0]        rotation_ff;
   logic               start_ff;
   logic               trig_busy;
   logic signed [F+1:0] cos_v, sin_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= 32'sd0;
         origin_y_ff   <= 32'sd0;
         rotation_ff   <= 16'd0;
         scale_x_ff    <= 32'sd65536;
         scale_y_ff    <= 32'sd65536;
         position_x_ff <= 32'sd0;
         position_y_ff <= 32'sd0;
         start_ff      <= 1'b1;
      end else begin
         start_ff <= csr_wr_en && (csr_index == CSR_ROTATION);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ORIGIN_X:   origin_x_ff   <= signed'(csr_data);
               CSR_ORIGIN_Y:   origin_y_ff   <= signed'(csr_data);
               CSR_ROTATION:   rotation_ff   <= csr_data[15:0];
               CSR_SCALE_X:    scale_x_ff    <= signed'(csr_data);
               CSR_SCALE_Y:    scale_y_ff    <= signed'(csr_data);
               CSR_POSITION_X: position_x_ff <= signed'(csr_data);
               CSR_POSITION_Y: position_y_ff <= signed'(csr_data);
               default: ;
            endcase
         end
      end
   end

   aff_trig #(.FRAC_BITS(F)) u_trig (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .rotation (rotation_ff),
      .busy     (trig_busy),
      .cos_out  (cos_v),
      .sin_out  (sin_v)
   );

   logic rsp_vld_ff;
   logic adv, accept;

   assign adv          = !rsp_vld_ff || rsp_if.ready;
   assign req_if.ready = adv && !trig_busy && !start_ff;
   assign accept       = req_if.valid && req_if.ready;

   // stage 1
   logic               vld1_ff, op1_ff, sat1_ff;
   logic signed [31:0] d1x_ff, d1y_ff;
   aff_sat_type        sub1x, sub1y;
   // stage 2
   logic               vld2_ff, op2_ff, sat2_ff;
   logic signed [31:0] d2x_ff, d2y_ff;
   logic signed [63:0] p2x_ff, p2y_ff;
   // stage 3
   logic               vld3_ff, op3_ff, sat3_ff;
   logic signed [31:0] u3x_ff, u3y_ff;
   aff_sat_type        sc3x, sc3y;
   // stage 4
   logic               vld4_ff, op4_ff, sat4_ff;
   logic signed [PW-1:0] ma_ff, mb_ff, me_ff, mf_ff;
   // stage 5
   logic               vld5_ff, op5_ff, sat5_ff;
   logic signed [SW-1:0] sx5_ff, sy5_ff;
   // stage 6
   logic               vld6_ff, op6_ff, sat6_ff;
   logic signed [31:0] r6x_ff, r6y_ff;
   aff_sat_type        rd6x, rd6y;
   // stage 7
   side_type           side7_ff, side7_in;
   logic [47:0]        numx_ff, numy_ff, numx_in, numy_in;
   logic [31:0]        denx_ff, deny_ff, denx_in, deny_in;
   aff_sat_type        fw7x, fw7y;
   logic [31:0]        magx, magy;

   always_comb begin
      sub1x = sat32(72'(req_if.point_x) -
                    72'(req_if.operation ? position_x_ff : origin_x_ff));
      sub1y = sat32(72'(req_if.point_y) -
                    72'(req_if.operation ? position_y_ff : origin_y_ff));
      sc3x  = sat32((72'(p2x_ff) + 72'sd32768) >>> 16);
      sc3y  = sat32((72'(p2y_ff) + 72'sd32768) >>> 16);
      rd6x  = sat32((72'(sx5_ff) + (72'sd1 <<< (F - 1))) >>> F);
      rd6y  = sat32((72'(sy5_ff) + (72'sd1 <<< (F - 1))) >>> F);
      fw7x  = sat32(72'(r6x_ff) + 72'(position_x_ff));
      fw7y  = sat32(72'(r6y_ff) + 72'(position_y_ff));

      magx    = r6x_ff[31] ? 32'(-r6x_ff) : r6x_ff;
      magy    = r6y_ff[31] ? 32'(-r6y_ff) : r6y_ff;
      denx_in = scale_x_ff[31] ? 32'(-scale_x_ff) : scale_x_ff;
      deny_in = scale_y_ff[31] ? 32'(-scale_y_ff) : scale_y_ff;
      numx_in = {magx, 16'h0000} + 48'(denx_in >> 1);
      numy_in = {magy, 16'h0000} + 48'(deny_in >> 1);

      side7_in.vld    = vld6_ff;
      side7_in.op     = op6_ff;
      side7_in.zero_x = op6_ff && (scale_x_ff == 32'sd0);
      side7_in.zero_y = op6_ff && (scale_y_ff == 32'sd0);
      side7_in.neg_x  = r6x_ff[31] ^ scale_x_ff[31];
      side7_in.neg_y  = r6y_ff[31] ^ scale_y_ff[31];
      side7_in.ovf_x  = (32'(numx_in[47:32]) >= denx_in);
      side7_in.ovf_y  = (32'(numy_in[47:32]) >= deny_in);
      if (op6_ff) begin
         side7_in.sat   = sat6_ff;
         side7_in.val_x = r6x_ff[31] ? WORD_MIN : WORD_MAX;
         side7_in.val_y = r6y_ff[31] ? WORD_MIN : WORD_MAX;
      end else begin
         side7_in.sat   = sat6_ff || fw7x.clipped || fw7y.clipped;
         side7_in.val_x = fw7x.value;
         side7_in.val_y = fw7y.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff      <= 1'b0;
         vld2_ff      <= 1'b0;
         vld3_ff      <= 1'b0;
         vld4_ff      <= 1'b0;
         vld5_ff      <= 1'b0;
         vld6_ff      <= 1'b0;
         side7_ff.vld <= 1'b0;
      end else if (adv) begin
         vld1_ff <= accept;
         op1_ff  <= req_if.operation;
         sat1_ff <= sub1x.clipped || sub1y.clipped;
         d1x_ff  <= signed'(sub1x.value);
         d1y_ff  <= signed'(sub1y.value);

         vld2_ff <= vld1_ff;
         op2_ff  <= op1_ff;
         sat2_ff <= sat1_ff;
         d2x_ff  <= d1x_ff;
         d2y_ff  <= d1y_ff;
         p2x_ff  <= 64'(d1x_ff) * 64'(scale_x_ff);
         p2y_ff  <= 64'(d1y_ff) * 64'(scale_y_ff);

         vld3_ff <= vld2_ff;
         op3_ff  <= op2_ff;
         if (op2_ff) begin
            sat3_ff <= sat2_ff;
            u3x_ff  <= d2x_ff;
            u3y_ff  <= d2y_ff;
         end else begin
            sat3_ff <= sat2_ff || sc3x.clipped || sc3y.clipped;
            u3x_ff  <= signed'(sc3x.value);
            u3y_ff  <= signed'(sc3y.value);
         end

         vld4_ff <= vld3_ff;
         op4_ff  <= op3_ff;
         sat4_ff <= sat3_ff;
         ma_ff   <= PW'(u3x_ff) * PW'(cos_v);
         mb_ff   <= PW'(u3y_ff) * PW'(sin_v);
         me_ff   <= PW'(u3x_ff) * PW'(sin_v);
         mf_ff   <= PW'(u3y_ff) * PW'(cos_v);

         vld5_ff <= vld4_ff;
         op5_ff  <= op4_ff;
         sat5_ff <= sat4_ff;
         if (op4_ff) begin
            sx5_ff <= SW'(ma_ff) + SW'(mb_ff);
            sy5_ff <= SW'(mf_ff) - SW'(me_ff);
         end else begin
            sx5_ff <= SW'(ma_ff) - SW'(mb_ff);
            sy5_ff <= SW'(me_ff) + SW'(mf_ff);
         end

         vld6_ff <= vld5_ff;
         op6_ff  <= op5_ff;
         sat6_ff <= sat5_ff || rd6x.clipped || rd6y.clipped;
         r6x_ff  <= signed'(rd6x.value);
         r6y_ff  <= signed'(rd6y.value);

         side7_ff <= side7_in;
         numx_ff  <= numx_in;
         numy_ff  <= numy_in;
         denx_ff  <= denx_in;
         deny_ff  <= deny_in;
      end
   end

   logic [31:0] quot_x, quot_y;

   aff_div u_div_x (
      .clock   (clock),
      .advance (adv),
      .num     (numx_ff),
      .den     (denx_ff),
      .quot    (quot_x)
   );

   aff_div u_div_y (
      .clock   (clock),
      .advance (adv),
      .num     (numy_ff),
      .den     (deny_ff),
      .quot    (quot_y)
   );

   side_type side_dly_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
      side_type side_cur;
      if (k == 0) begin : g_first
         assign side_cur = side7_ff;
      end else begin : g_next
         assign side_cur = side_dly_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            side_dly_ff[k].vld <= 1'b0;
         end else if (adv) begin
            side_dly_ff[k] <= side_cur;
         end
      end
   end

   side_type    side_out, side8_ff;
   logic [31:0] q8x_ff, q8y_ff, q8x_in, q8y_in;
   logic        qsat8x_ff, qsat8y_ff, qsat8x_in, qsat8y_in;
   aff_sat_type fin_x, fin_y;
   logic [31:0] res_x_in, res_y_in;
   logic        sat_in, zero_in;

   assign side_out = side_dly_ff[DIV_STAGES-1];

   always_comb begin
      if (side_out.ovf_x || (!side_out.neg_x && quot_x[31])) begin
         q8x_in    = side_out.neg_x ? WORD_MIN : WORD_MAX;
         qsat8x_in = 1'b1;
      end else if (side_out.neg_x && quot_x[31] && (quot_x[30:0] != 31'd0)) begin
         q8x_in    = WORD_MIN;
         qsat8x_in = 1'b1;
      end else begin
         q8x_in    = side_out.neg_x ? 32'(-quot_x) : quot_x;
         qsat8x_in = 1'b0;
      end
      if (side_out.ovf_y || (!side_out.neg_y && quot_y[31])) begin
         q8y_in    = side_out.neg_y ? WORD_MIN : WORD_MAX;
         qsat8y_in = 1'b1;
      end else if (side_out.neg_y && quot_y[31] && (quot_y[30:0] != 31'd0)) begin
         q8y_in    = WORD_MIN;
         qsat8y_in = 1'b1;
      end else begin
         q8y_in    = side_out.neg_y ? 32'(-quot_y) : quot_y;
         qsat8y_in = 1'b0;
      end

      fin_x = sat32(72'(signed'(q8x_ff)) + 72'(origin_x_ff));
      fin_y = sat32(72'(signed'(q8y_ff)) + 72'(origin_y_ff));
      sat_in = side8_ff.sat;
      if (side8_ff.op) begin
         if (side8_ff.zero_x) begin
            res_x_in = side8_ff.val_x;
         end else begin
            res_x_in = fin_x.value;
            sat_in   = sat_in || qsat8x_ff || fin_x.clipped;
         end
         if (side8_ff.zero_y) begin
            res_y_in = side8_ff.val_y;
         end else begin
            res_y_in = fin_y.value;
            sat_in   = sat_in || qsat8y_ff || fin_y.clipped;
         end
      end else begin
         res_x_in = side8_ff.val_x;
         res_y_in = side8_ff.val_y;
      end
      zero_in = side8_ff.zero_x || side8_ff.zero_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side8_ff.vld <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else if (adv) begin
         side8_ff  <= side_out;
         q8x_ff    <= q8x_in;
         q8y_ff    <= q8y_in;
         qsat8x_ff <= qsat8x_in;
         qsat8y_ff <= qsat8y_in;

         rsp_vld_ff      <= side8_ff.vld;
         rsp_if.result_x <= signed'(res_x_in);
         rsp_if.result_y <= signed'(res_y_in);
         rsp_if.status   <= zero_in ? STATUS_ZERO_SCALE :
                            (sat_in ? STATUS_SATURATED : STATUS_OK);
      end
   end

   assign rsp_if.valid = rsp_vld_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |-> !trig_busy)
      else $error("request taken while trig unit busy");

   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && (csr_index == CSR_ROTATION) |=> !req_if.ready)
      else $error("request ready right after rotation write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.status == STATUS_ZERO_SCALE) |->
         (rsp_if.result_x == WORD_MAX) || (rsp_if.result_x == WORD_MIN) ||
         (rsp_if.result_y == WORD_MAX) || (rsp_if.result_y == WORD_MIN))
      else $error("zero scale status without a clamped axis");

endmodule

@@ rtl/aff_trig.sv @@
module aff_trig
   import aff_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [15:0]            rotation,
   output logic                   busy,
   output logic signed [FRAC_BITS+1:0] cos_out,
   output logic signed [FRAC_BITS+1:0] sin_out
);

   localparam int SH = 30 - FRAC_BITS;

   typedef enum logic [1:0] {IDLE, RUN, FINISH} state_type;

   state_type          state_ff;
   logic [4:0]         step_ff;
   logic               flip_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic signed [33:0] x_in, y_in, z_in;
   logic signed [33:0] xs, ys;
   logic signed [33:0] atan_val;
   logic [15:0]        neg_rot;
   logic [31:0]        angle;
   logic               flip;
   logic signed [35:0] xf, yf, c_full, s_full;

   assign neg_rot  = 16'(17'h10000 - {1'b0, rotation});
   assign angle    = {neg_rot, 16'h0000};
   assign flip     = angle[31] ^ angle[30];
   assign atan_val = signed'({2'b00, atan_turns(step_ff)});

   always_comb begin
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      if (!z_ff[33]) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - atan_val;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + atan_val;
      end
      xf     = flip_ff ? -36'(x_ff) : 36'(x_ff);
      yf     = flip_ff ? -36'(y_ff) : 36'(y_ff);
      c_full = ((xf <<< 1) + (36'sd1 <<< SH)) >>> (SH + 1);
      s_full = ((yf <<< 1) + (36'sd1 <<< SH)) >>> (SH + 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else if (start) begin
         state_ff <= RUN;
         step_ff  <= 5'd0;
         flip_ff  <= flip;
         x_ff     <= CORDIC_GAIN;
         y_ff     <= 34'sd0;
         z_ff     <= 34'(signed'({angle[31] ^ flip, angle[30:0]}));
      end else begin
         case (state_ff)
            RUN: begin
               x_ff    <= x_in;
               y_ff    <= y_in;
               z_ff    <= z_in;
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(CORDIC_STEPS - 1)) state_ff <= FINISH;
            end
            FINISH: begin
               cos_out  <= c_full[FRAC_BITS+1:0];
               sin_out  <= s_full[FRAC_BITS+1:0];
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign busy = (state_ff != IDLE);

endmodule

@@ rtl/aff_div.sv @@
module aff_div
   import aff_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  logic [47:0] num,
   input  logic [31:0] den,
   output logic [31:0] quot
);

   logic [31:0] rem_ff [DIV_STAGES];
   logic [31:0] lo_ff  [DIV_STAGES];
   logic [31:0] den_ff [DIV_STAGES];
   logic [31:0] q_ff   [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [31:0] rem_cur, lo_cur, den_cur, q_cur;
      logic [32:0] trial;
      logic        ge;
      if (k == 0) begin : g_first
         assign rem_cur = {16'h0000, num[47:32]};
         assign lo_cur  = num[31:0];
         assign den_cur = den;
         assign q_cur   = 32'h0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign lo_cur  = lo_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign q_cur   = q_ff[k-1];
      end
      assign trial = {rem_cur, lo_cur[31]};
      assign ge    = (trial >= {1'b0, den_cur});
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= ge ? 32'(trial - {1'b0, den_cur}) : trial[31:0];
            lo_ff[k]  <= {lo_cur[30:0], 1'b0};
            den_ff[k] <= den_cur;
            q_ff[k]   <= {q_cur[30:0], ge};
         end
      end
   end

   assign quot = q_ff[DIV_STAGES-1];

endmodule
